FILE: design/ttp_pkg.sv
// Package for the timer task pool: sizes, operation and result codes,
// controller states and the structs passed between the controller and the cells.
// Has no dependencies.
package ttp_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = 3;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 2;
  localparam int DELAY_W    = 32;
  localparam int ADDR_SLOTS = 2 ** SLOT_W;
  localparam int USED_SLOTS = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_START = 3'd1,
    OP_TICK  = 3'd2,
    OP_RUN   = 3'd3,
    OP_CLEAR = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRE  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FULL,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay;
    logic               fast;
    logic               act;
    logic               go;
    logic               shift;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic stop;
  } cell_resp_t;

endpackage

FILE: design/ttp_in_if.sv
// Input channel of the timer task pool: valid, ready and one operation.
// Depends on ttp_pkg.
interface ttp_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttp_pkg::OP_W-1:0]    opcode;
  logic [ttp_pkg::SLOT_W-1:0]  slot_index;
  logic [ttp_pkg::DELAY_W-1:0] delay_ticks;
  logic                        run_in_tick;
  logic                        has_action;

  modport source (
    output valid, opcode, slot_index, delay_ticks, run_in_tick, has_action,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot_index, delay_ticks, run_in_tick, has_action,
    output ready
  );
endinterface

FILE: design/ttp_out_if.sv
// Result channel of the timer task pool: valid, ready and one result.
// Depends on ttp_pkg.
interface ttp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttp_pkg::KIND_W-1:0] result_kind;
  logic [ttp_pkg::SLOT_W-1:0] slot_number;
  logic                       last_item;

  modport source (
    output valid, result_kind, slot_number, last_item,
    input  ready
  );
  modport sink (
    input  valid, result_kind, slot_number, last_item,
    output ready
  );
endinterface

FILE: design/ttp_cell.sv
// One timer slot of the pool: its marks, its countdown and the walk token.
// Depends on ttp_pkg.
module ttp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttp_pkg::cell_cmd_t         cmd,
  input  logic [ttp_pkg::SLOT_W-1:0] cell_idx,
  input  logic                       tok_in,
  output logic                       tok_out,
  output ttp_pkg::cell_resp_t        resp
);
  import ttp_pkg::*;

  logic               occ_r, occ_nxt;
  logic               awake_r, awake_nxt;
  logic               fast_r, fast_nxt;
  logic               act_r, act_nxt;
  logic [DELAY_W-1:0] cnt_r, cnt_nxt;
  logic               tok_r, tok_nxt;
  logic [DELAY_W-1:0] cnt_dec;
  logic               active;

  always_comb begin
    active    = tok_r & cmd.go;
    cnt_dec   = (cnt_r != '0) ? (cnt_r - DELAY_W'(1)) : '0;
    occ_nxt   = occ_r;
    awake_nxt = awake_r;
    fast_nxt  = fast_r;
    act_nxt   = act_r;
    cnt_nxt   = cnt_r;
    resp.hit  = 1'b0;
    resp.stop = 1'b0;
    if (active) begin
      unique case (cmd.op)
        OP_ALLOC: begin
          if (!occ_r) begin
            occ_nxt   = 1'b1;
            resp.hit  = 1'b1;
            resp.stop = 1'b1;
          end
        end
        OP_START: begin
          if (cmd.slot == cell_idx) begin
            fast_nxt  = cmd.fast;
            act_nxt   = cmd.act;
            cnt_nxt   = cmd.delay;
            awake_nxt = 1'b1;
          end
        end
        OP_TICK: begin
          if (awake_r) begin
            cnt_nxt  = cnt_dec;
            resp.hit = (cnt_dec == '0) && fast_r && act_r;
          end
        end
        OP_RUN: begin
          if (awake_r && (cnt_r == '0) && !fast_r) begin
            awake_nxt = 1'b0;
            resp.hit  = act_r;
          end
        end
        OP_CLEAR: begin
          occ_nxt   = 1'b0;
          awake_nxt = 1'b0;
          fast_nxt  = 1'b0;
          act_nxt   = 1'b0;
          cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
    tok_nxt = cmd.shift ? tok_in : tok_r;
    tok_out = tok_r & ~resp.stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      awake_r <= 1'b0;
      fast_r  <= 1'b0;
      act_r   <= 1'b0;
      cnt_r   <= '0;
      tok_r   <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      awake_r <= awake_nxt;
      fast_r  <= fast_nxt;
      act_r   <= act_nxt;
      cnt_r   <= cnt_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

FILE: design/ttp_ctrl.sv
// Controller of the timer task pool: takes operations, steps the token along
// the cells and drives the result register. Depends on ttp_pkg and the channel interfaces.
module ttp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  ttp_in_if.sink              in_ch,
  ttp_out_if.source           out_ch,
  output ttp_pkg::cell_cmd_t  cmd,
  output logic                tok_start,
  input  ttp_pkg::cell_resp_t resp [ttp_pkg::USED_SLOTS]
);
  import ttp_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [OP_W-1:0]    op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [DELAY_W-1:0] delay_r;
  logic               fast_r;
  logic               act_r;
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [SLOT_W-1:0]  num_r, num_nxt;
  logic               last_r, last_nxt;
  logic               out_free;
  logic               accept;
  logic               advance;
  logic               any_hit;
  logic               any_stop;

  always_comb begin
    any_hit  = 1'b0;
    any_stop = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      any_hit  = any_hit | resp[i].hit;
      any_stop = any_stop | resp[i].stop;
    end
  end

  always_comb begin
    out_free      = !out_valid_r || out_ch.ready;
    in_ch.ready   = (state_r == S_IDLE);
    accept        = in_ch.valid && in_ch.ready;
    advance       = (state_r == S_WALK) && out_free;
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    num_nxt       = num_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WALK;
          pos_nxt   = '0;
        end
      end
      S_WALK: begin
        if (advance) begin
          if (any_hit) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = (op_r == OP_ALLOC) ? KIND_GRANT : KIND_FIRE;
            num_nxt       = pos_r;
            last_nxt      = 1'b0;
          end
          if (any_stop || (pos_r == SLOT_W'(USED_SLOTS - 1))) begin
            state_nxt = ((op_r == OP_ALLOC) && !any_stop) ? S_FULL : S_DONE;
          end else begin
            pos_nxt = pos_r + SLOT_W'(1);
          end
        end
      end
      S_FULL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_FULL;
          num_nxt       = '0;
          last_nxt      = 1'b0;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DONE;
          num_nxt       = '0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    num_r  <= num_nxt;
    last_r <= last_nxt;
    if (accept) begin
      op_r    <= in_ch.opcode;
      slot_r  <= in_ch.slot_index;
      delay_r <= in_ch.delay_ticks;
      fast_r  <= in_ch.run_in_tick;
      act_r   <= in_ch.has_action;
    end
  end

  always_comb begin
    cmd.op             = op_r;
    cmd.slot           = slot_r;
    cmd.delay          = delay_r;
    cmd.fast           = fast_r;
    cmd.act            = act_r;
    cmd.go             = advance;
    cmd.shift          = advance || accept;
    tok_start          = accept;
    out_ch.valid       = out_valid_r;
    out_ch.result_kind = kind_r;
    out_ch.slot_number = num_r;
    out_ch.last_item   = last_r;
  end

endmodule

FILE: design/timer_task_pool.sv
// Timer task pool top level: a row of eight timer cells and the controller.
// Depends on ttp_pkg, ttp_in_if, ttp_out_if, ttp_cell and ttp_ctrl.
//
// Each operation (allocate, start, tick, run pending, clear all) is one input
// transfer. A token then steps through the slot cells, one cell per cycle, in
// ascending slot order; the cell holding the token does its part of the
// operation, and a grant or a fire is placed in the output register at once.
// Allocate stops at the first free slot. Every operation ends with a done
// result, preceded by a pool-full result when allocate finds no free slot.
// The token walk pauses while a result waits in the output register to be
// taken. A new operation is taken once the done result has been registered.
module timer_task_pool (
  input  logic      clk,
  input  logic      rst_n,
  ttp_in_if.sink    in_ch,
  ttp_out_if.source out_ch
);
  import ttp_pkg::*;

  cell_cmd_t  cmd;
  logic       tok_start;
  logic       tok_chain [USED_SLOTS];
  cell_resp_t resp [USED_SLOTS];

  ttp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .tok_start (tok_start),
    .resp      (resp)
  );

  for (genvar i = 0; i < USED_SLOTS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = tok_start;
    end else begin : g_body
      assign tok_in = tok_chain[i-1];
    end
    ttp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cell_idx (SLOT_W'(i)),
      .tok_in   (tok_in),
      .tok_out  (tok_chain[i]),
      .resp     (resp[i])
    );
  end

endmodule
